### sv/otg_rd_pkg.sv
package otg_rd_pkg;

   // Field and register widths.
   localparam int unsigned TICK_W = 16;
   localparam int unsigned ROLE_W = 2;
   localparam int unsigned MODE_W = 3;

   // Debounce length after reset, in ticks.
   localparam logic [TICK_W-1:0] DEBOUNCE_RESET = TICK_W'(100);
   localparam logic [TICK_W-1:0] TICK_MAX       = '1;

   // Configuration register indexes.
   localparam logic CSR_DEBOUNCE_TICKS = 1'b0;
   localparam logic CSR_OTG_ENABLED    = 1'b1;

   // Settled role codes.
   localparam logic [ROLE_W-1:0] ROLE_NONE   = 2'd0;
   localparam logic [ROLE_W-1:0] ROLE_DEVICE = 2'd1;
   localparam logic [ROLE_W-1:0] ROLE_HOST   = 2'd2;

   typedef enum logic [MODE_W-1:0] {
      ST_UNKNOWN    = 3'd0,
      ST_DEVICE     = 3'd1,
      ST_HOST       = 3'd2,
      ST_DEB_DEVICE = 3'd3,
      ST_DEB_HOST   = 3'd4,
      ST_FAULT      = 3'd5
   } state_type;

   // Machine and timer state carried from one tick to the next.
   typedef struct packed {
      state_type         fsm_state;
      logic              timer_armed;
      logic [TICK_W-1:0] elapsed_ticks;
      logic [ROLE_W-1:0] current_role;
   } ctx_type;

   // Configuration as seen by the transition logic.
   typedef struct packed {
      logic [TICK_W-1:0] debounce_ticks;
      logic              otg_enabled;
   } cfg_type;

   // Flags reported for one tick.
   typedef struct packed {
      logic role_changed;
      logic reinit_request;
   } flags_type;

endpackage

### sv/otg_rd_step.sv
module otg_rd_step (
   input  otg_rd_pkg::ctx_type   ctx_i,
   input  otg_rd_pkg::cfg_type   cfg_i,
   input  logic                  overcurrent_level_i,
   input  logic                  id_level_i,
   output otg_rd_pkg::ctx_type   ctx_o,
   output otg_rd_pkg::flags_type flags_o
);
   import otg_rd_pkg::*;

   // One tick: advance the timer, then the overcurrent, ID and expiry events in turn.
   always_comb begin
      ctx_type   nxt;
      flags_type flg;
      nxt = ctx_i;
      flg = '0;

      // An armed timer counts one more tick and saturates.
      if (nxt.timer_armed && (nxt.elapsed_ticks != TICK_MAX)) begin
         nxt.elapsed_ticks = nxt.elapsed_ticks + TICK_W'(1);
      end

      // Overcurrent asserted: every live state goes to fault, and fault re-arms.
      if (!overcurrent_level_i) begin
         case (nxt.fsm_state)
            ST_UNKNOWN, ST_DEVICE, ST_HOST, ST_DEB_DEVICE, ST_DEB_HOST, ST_FAULT: begin
               nxt.fsm_state     = ST_FAULT;
               nxt.timer_armed   = 1'b1;
               nxt.elapsed_ticks = '0;
            end
            default: begin
            end
         endcase
      end

      // ID pin level.
      if (!id_level_i) begin
         case (nxt.fsm_state)
            ST_UNKNOWN, ST_DEVICE: begin
               nxt.fsm_state     = ST_DEB_HOST;
               nxt.timer_armed   = 1'b1;
               nxt.elapsed_ticks = '0;
            end
            ST_DEB_DEVICE: begin
               nxt.fsm_state   = ST_HOST;
               nxt.timer_armed = 1'b0;
               flg.role_changed = 1'b1;
            end
            default: begin
            end
         endcase
      end else begin
         case (nxt.fsm_state)
            ST_UNKNOWN, ST_HOST: begin
               nxt.fsm_state     = ST_DEB_DEVICE;
               nxt.timer_armed   = 1'b1;
               nxt.elapsed_ticks = '0;
            end
            ST_DEB_HOST: begin
               nxt.fsm_state   = ST_DEVICE;
               nxt.timer_armed = 1'b0;
               flg.role_changed = 1'b1;
            end
            default: begin
            end
         endcase
      end

      // Timer expiry disarms in any state; only debounce and fault act on it.
      if (nxt.timer_armed && (nxt.elapsed_ticks >= cfg_i.debounce_ticks)) begin
         nxt.timer_armed = 1'b0;
         case (nxt.fsm_state)
            ST_DEB_DEVICE: begin
               nxt.fsm_state    = ST_DEVICE;
               flg.role_changed = 1'b1;
            end
            ST_DEB_HOST, ST_FAULT: begin
               nxt.fsm_state    = ST_HOST;
               flg.role_changed = 1'b1;
            end
            default: begin
            end
         endcase
      end

      // At most one entry per tick, and the machine then rests in the entered state.
      if (flg.role_changed) begin
         nxt.current_role   = (nxt.fsm_state == ST_DEVICE) ? ROLE_DEVICE : ROLE_HOST;
         flg.reinit_request = cfg_i.otg_enabled && (nxt.current_role != ctx_i.current_role);
      end

      ctx_o   = nxt;
      flags_o = flg;
   end

endmodule

### sv/otg_role_debounce_fsm.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  overcurrent_level, id_level
// rsp_      out        rsp_valid / rsp_ready  mode_state, role, role_changed, reinit_request
// csr_      in         csr_wr_en              csr_index, csr_wr_data
//
// Each tick transfer yields exactly one result transfer. One tick is accepted every
// cycle unless stalled; the state update sits between the input register and the
// result register. A stalled result holds the result register, and req_ready drops
// once the input register also holds a tick.
// Synchronous active-high reset returns the machine to unknown, disarms the timer
// and restores debounce_ticks to 100 and otg_enabled to 0.
module otg_role_debounce_fsm (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_overcurrent_level,
   input  logic                            req_id_level,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [otg_rd_pkg::MODE_W-1:0]   rsp_mode_state,
   output logic [otg_rd_pkg::ROLE_W-1:0]   rsp_role,
   output logic                            rsp_role_changed,
   output logic                            rsp_reinit_request,
   input  logic                            csr_wr_en,
   input  logic                            csr_index,
   input  logic [otg_rd_pkg::TICK_W-1:0]   csr_wr_data
);
   import otg_rd_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   ctx_type   ctx_ff, ctx_in;
   flags_type flags_in;
   logic      in_valid_ff;
   logic      in_oc_ff;
   logic      in_id_ff;
   logic      out_valid_ff;
   logic [MODE_W-1:0] out_mode_ff;
   logic [ROLE_W-1:0] out_role_ff;
   logic      out_changed_ff;
   logic      out_reinit_ff;
   logic      out_free;
   logic      advance;

   // The result register can take a new result when empty or being drained.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   // Configuration writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_DEBOUNCE_TICKS: cfg_in.debounce_ticks = csr_wr_data;
            CSR_OTG_ENABLED:    cfg_in.otg_enabled    = csr_wr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks <= DEBOUNCE_RESET;
         cfg_ff.otg_enabled    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_oc_ff <= req_overcurrent_level;
         in_id_ff <= req_id_level;
      end
   end

   // Transition logic for one tick.
   otg_rd_step u_step (
      .ctx_i               (ctx_ff),
      .cfg_i               (cfg_ff),
      .overcurrent_level_i (in_oc_ff),
      .id_level_i          (in_id_ff),
      .ctx_o               (ctx_in),
      .flags_o             (flags_in)
   );

   // Machine state moves only when a tick passes into the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff.fsm_state     <= ST_UNKNOWN;
         ctx_ff.timer_armed   <= 1'b0;
         ctx_ff.elapsed_ticks <= '0;
         ctx_ff.current_role  <= ROLE_NONE;
      end else if (advance) begin
         ctx_ff <= ctx_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_mode_ff    <= MODE_W'(ctx_in.fsm_state);
         out_role_ff    <= ctx_in.current_role;
         out_changed_ff <= flags_in.role_changed;
         out_reinit_ff  <= flags_in.reinit_request;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_mode_state     = out_mode_ff;
   assign rsp_role           = out_role_ff;
   assign rsp_role_changed   = out_changed_ff;
   assign rsp_reinit_request = out_reinit_ff;

endmodule

### sv/otg_rd_checker.sv
module otg_rd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [otg_rd_pkg::MODE_W-1:0]   rsp_mode_state,
   input logic [otg_rd_pkg::ROLE_W-1:0]   rsp_role,
   input logic                            rsp_role_changed,
   input logic                            rsp_reinit_request
);
   import otg_rd_pkg::*;

   // A stalled result holds until its transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mode_state) && $stable(rsp_role)
         && $stable(rsp_role_changed) && $stable(rsp_reinit_request))
      else $error("result changed while stalled");

   // A reinit request only comes with a role change.
   a_reinit_needs_change: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reinit_request |-> rsp_role_changed)
      else $error("reinit request without role change");

   // A settled device state always reports the device role.
   a_device_role: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_mode_state == MODE_W'(ST_DEVICE)) |-> rsp_role == ROLE_DEVICE)
      else $error("device state with wrong role");

   // A settled host state always reports the host role.
   a_host_role: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_mode_state == MODE_W'(ST_HOST)) |-> rsp_role == ROLE_HOST)
      else $error("host state with wrong role");

   // A role change is reported only on entry to device or host.
   a_change_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_role_changed |->
         (rsp_mode_state == MODE_W'(ST_DEVICE)) || (rsp_mode_state == MODE_W'(ST_HOST)))
      else $error("role change outside device or host state");

endmodule

bind otg_role_debounce_fsm otg_rd_checker u_otg_rd_checker (.*);
